FILE: src/matrix_multiply_transpose_modes_assert.svh
// assertion macros shared by the rtl
`ifndef MATRIX_MULTIPLY_TRANSPOSE_MODES_ASSERT_SVH
`define MATRIX_MULTIPLY_TRANSPOSE_MODES_ASSERT_SVH

// same-cycle implication, off during reset
`define MMTM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mmtm assertion failed");

// next-cycle implication, off during reset
`define MMTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mmtm assertion failed");

`endif

FILE: src/mmtm_pkg.sv
`default_nettype none

package mmtm_pkg;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;
    localparam int IDX_W  = 12;
    localparam int CFG_W  = 7;
    localparam int MODE_W = 2;

    typedef enum logic [1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_ROWS_M      = 2'd0;
    localparam logic [1:0] REG_INNER_K     = 2'd1;
    localparam logic [1:0] REG_COLS_N      = 2'd2;
    localparam logic [1:0] REG_LAYOUT_MODE = 2'd3;

    localparam logic [MODE_W-1:0] LAYOUT_A_T = 2'd1;
    localparam logic [MODE_W-1:0] LAYOUT_B_T = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH0,
        S_FLUSH1
    } t_state;

    // tag that travels with each issued multiply-accumulate
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctrl;

endpackage

`default_nettype wire

FILE: src/mmtm_seq.sv
`default_nettype none

module mmtm_seq #(
    parameter int MAX_DIM = 64
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire  [$clog2(MAX_DIM+1)-1:0]       i_m,
    input  wire  [$clog2(MAX_DIM+1)-1:0]       i_k,
    input  wire  [$clog2(MAX_DIM+1)-1:0]       i_n,
    input  wire                                i_a_tr,
    input  wire                                i_b_tr,
    output logic                               o_busy,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_a_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_b_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_c_addr,
    output mmtm_pkg::t_mac_ctrl                o_ctrl
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    mmtm_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]  r_i, n_i, r_j, n_j, r_p, n_p;
    logic [DIM_W-1:0]  r_m, n_m, r_k, n_k, r_n, n_n;
    logic              r_a_tr, n_a_tr, r_b_tr, n_b_tr;
    logic [ADDR_W-1:0] r_a_addr, n_a_addr, r_b_addr, n_b_addr;
    logic [ADDR_W-1:0] r_a_base, n_a_base, r_b_base, n_b_base;
    logic [ADDR_W-1:0] r_c_addr, n_c_addr;

    logic last_p, last_j, last_i;

    always_comb begin
        last_p = (DIM_W'(r_p) == r_k - DIM_W'(1));
        last_j = (DIM_W'(r_j) == r_n - DIM_W'(1));
        last_i = (DIM_W'(r_i) == r_m - DIM_W'(1));

        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_p      = r_p;
        n_m      = r_m;
        n_k      = r_k;
        n_n      = r_n;
        n_a_tr   = r_a_tr;
        n_b_tr   = r_b_tr;
        n_a_addr = r_a_addr;
        n_b_addr = r_b_addr;
        n_a_base = r_a_base;
        n_b_base = r_b_base;
        n_c_addr = r_c_addr;

        o_busy       = (r_state != mmtm_pkg::S_IDLE);
        o_ctrl.valid = 1'b0;
        o_ctrl.first = (r_p == '0);
        o_ctrl.last  = last_p;

        case (r_state)
            mmtm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state  = mmtm_pkg::S_RUN;
                    n_i      = '0;
                    n_j      = '0;
                    n_p      = '0;
                    n_m      = i_m;
                    n_k      = i_k;
                    n_n      = i_n;
                    n_a_tr   = i_a_tr;
                    n_b_tr   = i_b_tr;
                    n_a_addr = '0;
                    n_b_addr = '0;
                    n_a_base = '0;
                    n_b_base = '0;
                    n_c_addr = '0;
                end
            end
            mmtm_pkg::S_RUN: begin
                o_ctrl.valid = 1'b1;
                if (!last_p) begin
                    n_p      = r_p + CNT_W'(1);
                    n_a_addr = r_a_addr + (r_a_tr ? ADDR_W'(r_m) : ADDR_W'(1));
                    n_b_addr = r_b_addr + (r_b_tr ? ADDR_W'(1) : ADDR_W'(r_n));
                end else begin
                    n_p      = '0;
                    n_c_addr = r_c_addr + ADDR_W'(1);
                    if (!last_j) begin
                        // next column, same row of the left operand
                        n_j      = r_j + CNT_W'(1);
                        n_a_addr = r_a_base;
                        n_b_base = r_b_base + (r_b_tr ? ADDR_W'(r_k) : ADDR_W'(1));
                        n_b_addr = n_b_base;
                    end else begin
                        n_j      = '0;
                        n_b_base = '0;
                        n_b_addr = '0;
                        if (!last_i) begin
                            n_i      = r_i + CNT_W'(1);
                            n_a_base = r_a_base + (r_a_tr ? ADDR_W'(1) : ADDR_W'(r_k));
                            n_a_addr = n_a_base;
                        end else begin
                            n_state = mmtm_pkg::S_FLUSH0;
                        end
                    end
                end
            end
            mmtm_pkg::S_FLUSH0: n_state = mmtm_pkg::S_FLUSH1;
            mmtm_pkg::S_FLUSH1: n_state = mmtm_pkg::S_IDLE;
            default:            n_state = mmtm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmtm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_p      <= n_p;
        r_m      <= n_m;
        r_k      <= n_k;
        r_n      <= n_n;
        r_a_tr   <= n_a_tr;
        r_b_tr   <= n_b_tr;
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
        r_a_base <= n_a_base;
        r_b_base <= n_b_base;
        r_c_addr <= n_c_addr;
    end

    assign o_a_addr = r_a_addr;
    assign o_b_addr = r_b_addr;
    assign o_c_addr = r_c_addr;

endmodule

`default_nettype wire

FILE: src/mmtm_mac.sv
`default_nettype none

module mmtm_mac #(
    parameter int ADDR_W = 12
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire         mmtm_pkg::t_mac_ctrl         i_ctrl,
    input  wire         [ADDR_W-1:0]                 i_c_addr,
    input  wire  signed [mmtm_pkg::VAL_W-1:0]        i_a_data,
    input  wire  signed [mmtm_pkg::VAL_W-1:0]        i_b_data,
    output logic                                     o_wr_en,
    output logic        [ADDR_W-1:0]                 o_wr_addr,
    output logic signed [mmtm_pkg::ACC_W-1:0]        o_wr_data
);

    localparam int EXT_W = mmtm_pkg::ACC_W - mmtm_pkg::PROD_W;

    // stage 1 lines up with the registered store read, stage 2 with the product
    mmtm_pkg::t_mac_ctrl r_ctrl1, r_ctrl2;
    logic [ADDR_W-1:0]   r_c_addr1, r_c_addr2;

    logic signed [mmtm_pkg::PROD_W-1:0] r_prod;
    logic signed [mmtm_pkg::ACC_W-1:0]  r_acc;
    logic signed [mmtm_pkg::ACC_W-1:0]  prod_ext;
    logic signed [mmtm_pkg::ACC_W-1:0]  acc_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl1 <= '0;
            r_ctrl2 <= '0;
        end else begin
            r_ctrl1 <= i_ctrl;
            r_ctrl2 <= r_ctrl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_addr1 <= i_c_addr;
        r_c_addr2 <= r_c_addr1;
        r_prod    <= i_a_data * i_b_data;
    end

    always_comb begin
        prod_ext = {{EXT_W{r_prod[mmtm_pkg::PROD_W-1]}}, r_prod};
        acc_sum  = r_ctrl2.first ? prod_ext : r_acc + prod_ext;
    end

    always_ff @(posedge i_clk) begin
        if (r_ctrl2.valid) begin
            r_acc <= acc_sum;
        end
    end

    assign o_wr_en   = r_ctrl2.valid & r_ctrl2.last;
    assign o_wr_addr = r_c_addr2;
    assign o_wr_data = acc_sum;

endmodule

`default_nettype wire

FILE: src/matrix_multiply_transpose_modes.sv
`default_nettype none

`include "matrix_multiply_transpose_modes_assert.svh"

// Fixed-point matrix multiply with selectable operand layout. Operands A and B
// (signed Q4.12) are loaded one element per command into flat row-major stores;
// a compute command fills the rows_m x cols_n product C = A*B (signed Q16.24,
// 40-bit exact sums) and a read command returns one product element by index.
// Commands are taken when start is high and busy is low. Load and read
// commands may follow back to back. A read answers in the cycle after it
// is taken, with o_result_valid high for a single cycle; the receiver
// cannot stall, so it must take every result as it comes. A compute
// holds busy high while a single multiply-accumulate unit does one term
// per cycle under the sequencer, and through the flush states that drain
// its read and multiply stages. layout_mode 1 takes A
// stored k-by-m, 2 takes B stored n-by-k, 3 acts as plain. Dimensions outside
// 1..MAX_DIM are clamped. The stores hold garbage until written: do not use
// operands or read products that were never written. Product entries outside
// the computed region keep their values; reads past the store return zero.
// Configuration writes are meant for idle time only.
module matrix_multiply_transpose_modes #(
    parameter int MAX_DIM = 64
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // command channel
    input  wire                                   start,
    output logic                                  busy,
    input  wire         [1:0]                     i_command,
    input  wire         [mmtm_pkg::IDX_W-1:0]     i_element_index,
    input  wire  signed [mmtm_pkg::VAL_W-1:0]     i_element_value,
    // result channel
    output logic                                  o_result_valid,
    output logic        [mmtm_pkg::IDX_W-1:0]     o_result_index,
    output logic signed [mmtm_pkg::ACC_W-1:0]     o_result_value,
    // configuration channel
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire         [1:0]                     i_cfg_index,
    input  wire         [mmtm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);

    // configuration registers
    logic [mmtm_pkg::CFG_W-1:0]  r_rows_m, r_inner_k, r_cols_n;
    logic [mmtm_pkg::MODE_W-1:0] r_layout_mode;

    // operand and product stores
    logic signed [mmtm_pkg::VAL_W-1:0] left_mem    [DEPTH];
    logic signed [mmtm_pkg::VAL_W-1:0] right_mem   [DEPTH];
    logic signed [mmtm_pkg::ACC_W-1:0] product_mem [DEPTH];

    logic signed [mmtm_pkg::VAL_W-1:0] r_a_data, r_b_data;
    logic signed [mmtm_pkg::ACC_W-1:0] r_rd_data;
    logic                              r_rd_valid, r_rd_inside;
    logic [mmtm_pkg::IDX_W-1:0]        r_rd_index;

    logic              cmd_take, take_wr_a, take_wr_b, take_compute, take_read;
    logic              idx_inside;
    logic [ADDR_W-1:0] idx_addr;
    logic [DIM_W-1:0]  m_used, k_used, n_used;
    logic              cfg_take;

    // sequencer and mac wiring
    logic                 seq_busy;
    logic [ADDR_W-1:0]    seq_a_addr, seq_b_addr, seq_c_addr;
    mmtm_pkg::t_mac_ctrl  seq_ctrl;
    logic                 mac_wr_en;
    logic [ADDR_W-1:0]    mac_wr_addr;
    logic signed [mmtm_pkg::ACC_W-1:0] mac_wr_data;

    // command decode
    always_comb begin
        busy         = seq_busy;
        cmd_take     = start & ~seq_busy;
        take_wr_a    = cmd_take & (i_command == mmtm_pkg::CMD_WRITE_A);
        take_wr_b    = cmd_take & (i_command == mmtm_pkg::CMD_WRITE_B);
        take_compute = cmd_take & (i_command == mmtm_pkg::CMD_COMPUTE);
        take_read    = cmd_take & (i_command == mmtm_pkg::CMD_READ);
        idx_inside   = (32'(i_element_index) < DEPTH);
        idx_addr     = ADDR_W'(i_element_index);
    end

    // dimension clamp to 1..MAX_DIM
    always_comb begin
        m_used = (r_rows_m == '0) ? DIM_W'(1) :
                 (32'(r_rows_m) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_rows_m);
        k_used = (r_inner_k == '0) ? DIM_W'(1) :
                 (32'(r_inner_k) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_inner_k);
        n_used = (r_cols_n == '0) ? DIM_W'(1) :
                 (32'(r_cols_n) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_cols_n);
    end

    // config write transaction
    assign o_cfg_ready = ~seq_busy;
    assign cfg_take    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m      <= mmtm_pkg::CFG_W'(1);
            r_inner_k     <= mmtm_pkg::CFG_W'(1);
            r_cols_n      <= mmtm_pkg::CFG_W'(1);
            r_layout_mode <= '0;
        end else if (cfg_take) begin
            case (i_cfg_index)
                mmtm_pkg::REG_ROWS_M:      r_rows_m      <= i_cfg_data;
                mmtm_pkg::REG_INNER_K:     r_inner_k     <= i_cfg_data;
                mmtm_pkg::REG_COLS_N:      r_cols_n      <= i_cfg_data;
                mmtm_pkg::REG_LAYOUT_MODE: r_layout_mode <= i_cfg_data[mmtm_pkg::MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // loop sequencer: walks i, j, p and hands out operand addresses
    mmtm_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (take_compute),
        .i_m      (m_used),
        .i_k      (k_used),
        .i_n      (n_used),
        .i_a_tr   (r_layout_mode == mmtm_pkg::LAYOUT_A_T),
        .i_b_tr   (r_layout_mode == mmtm_pkg::LAYOUT_B_T),
        .o_busy   (seq_busy),
        .o_a_addr (seq_a_addr),
        .o_b_addr (seq_b_addr),
        .o_c_addr (seq_c_addr),
        .o_ctrl   (seq_ctrl)
    );

    // operand stores: load port and sequencer read port
    always_ff @(posedge i_clk) begin
        if (take_wr_a && idx_inside) begin
            left_mem[idx_addr] <= i_element_value;
        end
        r_a_data <= left_mem[seq_a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (take_wr_b && idx_inside) begin
            right_mem[idx_addr] <= i_element_value;
        end
        r_b_data <= right_mem[seq_b_addr];
    end

    // shared multiply-accumulate unit
    mmtm_mac #(
        .ADDR_W (ADDR_W)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (seq_ctrl),
        .i_c_addr  (seq_c_addr),
        .i_a_data  (r_a_data),
        .i_b_data  (r_b_data),
        .o_wr_en   (mac_wr_en),
        .o_wr_addr (mac_wr_addr),
        .o_wr_data (mac_wr_data)
    );

    // product store: mac write port and command read port
    always_ff @(posedge i_clk) begin
        if (mac_wr_en) begin
            product_mem[mac_wr_addr] <= mac_wr_data;
        end
        r_rd_data <= product_mem[idx_addr];
    end

    // read transaction answer, registered in the cycle after the command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= take_read;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_index  <= i_element_index;
        r_rd_inside <= idx_inside;
    end

    assign o_result_valid = r_rd_valid;
    assign o_result_index = r_rd_index;
    assign o_result_value = r_rd_inside ? r_rd_data : '0;

    // a result only follows a taken read
    `MMTM_ASSERT_IMPLY(a_result_after_read, i_clk, i_rst_n, o_result_valid, $past(take_read))
    // product writes only happen inside a compute
    `MMTM_ASSERT_IMPLY(a_write_while_busy, i_clk, i_rst_n, mac_wr_en, seq_busy)
    // a taken compute blocks further commands
    `MMTM_ASSERT_NEXT(a_compute_busy, i_clk, i_rst_n, take_compute, seq_busy)
    // reads past the store answer zero
    `MMTM_ASSERT_NEXT(a_outside_zero, i_clk, i_rst_n, take_read && !idx_inside, o_result_value == '0)

endmodule

`default_nettype wire
